>>> design/gn2d_pkg.sv
package gn2d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 20;
  localparam int CELL_W     = POS_W - FRAC_BITS;
  localparam int IDX_W      = 5;
  localparam int GRAD_W     = 16;
  localparam int DOT_W      = 25;
  localparam int BL_W       = 28;
  localparam int DOT_SHIFT  = 14 + FRAC_BITS - 20;
  localparam int OUT_SHIFT  = 20 - 15;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_t;

  typedef struct packed {
    logic                     func;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic [IDX_W-1:0]         lattice_col;
    logic [IDX_W-1:0]         lattice_row;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] noise;
    logic               out_of_range;
  } out_t;

  typedef struct packed {
    logic                     is_eval;
    logic                     wr_ok;
    logic                     oor;
    logic [IDX_W-1:0]         col;
    logic [IDX_W-1:0]         row;
    logic [FRAC_BITS-1:0]     fx;
    logic [FRAC_BITS-1:0]     fy;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } cmd_t;

  function automatic logic signed [38:0] fade_at(logic [FRAC_BITS-1:0] t);
    logic signed [21:0] ts;
    logic signed [21:0] a;
    logic signed [38:0] p;
    ts = $signed({6'b0, t});
    a  = ts * 22'sd6 - 22'sd983040;
    p  = a * $signed({1'b0, t});
    return p;
  endfunction

  function automatic logic [FRAC_BITS-1:0] fade_sq(logic [FRAC_BITS-1:0] x,
                                                   logic [FRAC_BITS-1:0] t);
    logic [2*FRAC_BITS-1:0] p;
    p = x * t;
    return p[2*FRAC_BITS-1:FRAC_BITS];
  endfunction

  function automatic logic signed [21:0] fade_c(logic signed [38:0] at);
    logic signed [38:0] s;
    s = (at >>> FRAC_BITS) + 39'sd655360;
    return s[21:0];
  endfunction

  function automatic logic [FRAC_BITS:0] fade_u(logic [FRAC_BITS-1:0] t3,
                                                logic signed [21:0] c);
    logic signed [38:0] p;
    logic signed [38:0] s;
    p = $signed({1'b0, t3}) * c;
    s = p >>> FRAC_BITS;
    if (s < 39'sd0) return '0;
    if (s > 39'sd65536) return 17'd65536;
    return s[FRAC_BITS:0];
  endfunction

  function automatic logic signed [DOT_W-1:0] corner_dot(
      logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy,
      logic signed [17:0] ox, logic signed [17:0] oy);
    logic signed [34:0] s;
    logic signed [34:0] f;
    s = gx * ox + gy * oy;
    f = s >>> DOT_SHIFT;
    return f[DOT_W-1:0];
  endfunction

  function automatic logic signed [BL_W-1:0] blend(logic signed [BL_W-1:0] p,
                                                   logic signed [BL_W-1:0] q,
                                                   logic [FRAC_BITS:0] u);
    logic signed [47:0] d;
    logic signed [47:0] m;
    logic signed [47:0] r;
    d = 48'(q) - 48'(p);
    m = d * $signed({1'b0, u});
    r = 48'(p) + (m >>> FRAC_BITS);
    return r[BL_W-1:0];
  endfunction

endpackage

>>> design/gn2d_front.sv
module gn2d_front #(
  parameter int MAX_CELLS = 16
) (
  input  gn2d_pkg::in_t                  in_data,
  input  logic [gn2d_pkg::CFG_W-1:0]     cells,
  output gn2d_pkg::cmd_t                 cmd
);
  import gn2d_pkg::*;

  logic [7:0]        limit;
  logic [CELL_W-1:0] cx;
  logic [CELL_W-1:0] cy;

  always_comb begin
    limit = (8'(cells) > 8'(MAX_CELLS)) ? 8'(MAX_CELLS) : 8'(cells);
    cx    = in_data.pos_x[POS_W-1:FRAC_BITS];
    cy    = in_data.pos_y[POS_W-1:FRAC_BITS];
    cmd.is_eval = (in_data.func == FUNC_EVAL);
    cmd.wr_ok   = (8'(in_data.lattice_col) <= 8'(MAX_CELLS)) &&
                  (8'(in_data.lattice_row) <= 8'(MAX_CELLS));
    cmd.oor     = (8'(cx) >= limit) || (8'(cy) >= limit);
    cmd.fx      = in_data.pos_x[FRAC_BITS-1:0];
    cmd.fy      = in_data.pos_y[FRAC_BITS-1:0];
    cmd.gx      = in_data.grad_x;
    cmd.gy      = in_data.grad_y;
    if (in_data.func == FUNC_EVAL) begin
      cmd.col = IDX_W'(cx);
      cmd.row = IDX_W'(cy);
    end else begin
      cmd.col = in_data.lattice_col;
      cmd.row = in_data.lattice_row;
    end
  end

endmodule

>>> design/gn2d_queue.sv
module gn2d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  gn2d_pkg::cmd_t push_data,
  input  logic           pop,
  output logic           pop_valid,
  output gn2d_pkg::cmd_t pop_data
);
  import gn2d_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          buf_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = buf_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) buf_r[wp_r] <= push_data;
  end

endmodule

>>> design/gn2d_back.sv
module gn2d_back #(
  parameter int MAX_CELLS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  gn2d_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output gn2d_pkg::out_t out_data
);
  import gn2d_pkg::*;

  localparam int SIDE  = MAX_CELLS + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];

  logic          en;
  logic [AW-1:0] base, a00, a10, a01, a11;

  logic [31:0] rd00_r, rd10_r, rd01_r, rd11_r;

  logic                   v1_r, oor1_r;
  logic [FRAC_BITS-1:0]   fx1_r, fy1_r, ttx1_r, tty1_r;
  logic signed [38:0]     atx1_r, aty1_r;

  logic                   v2_r, oor2_r;
  logic signed [DOT_W-1:0] d00_2_r, d10_2_r, d01_2_r, d11_2_r;
  logic [FRAC_BITS-1:0]   t3x2_r, t3y2_r;
  logic signed [21:0]     cx2_r, cy2_r;

  logic                   v3_r, oor3_r;
  logic signed [DOT_W-1:0] d00_3_r, d10_3_r, d01_3_r, d11_3_r;
  logic [FRAC_BITS:0]     ux3_r, uy3_r;

  logic                   v4_r, oor4_r;
  logic signed [BL_W-1:0] i0_4_r, i1_4_r;
  logic [FRAC_BITS:0]     uy4_r;

  logic                   out_valid_r;
  out_t                   out_r;

  logic signed [17:0]     ox0, ox1, oy0, oy1;
  logic signed [BL_W-1:0] vb;
  logic signed [BL_W-1:0] vs;
  logic signed [15:0]     sat;

  assign en        = !out_valid_r || out_ready;
  assign q_pop     = q_valid && en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    base = AW'(32'(q_cmd.row) * 32'(SIDE) + 32'(q_cmd.col));
    a00  = q_cmd.oor ? '0 : base;
    a10  = a00 + AW'(1);
    a01  = a00 + AW'(SIDE);
    a11  = a01 + AW'(1);
    ox0  = $signed({2'b0, fx1_r});
    oy0  = $signed({2'b0, fy1_r});
    ox1  = ox0 - 18'sd65536;
    oy1  = oy0 - 18'sd65536;
    vb   = blend(i0_4_r, i1_4_r, uy4_r);
    vs   = vb >>> OUT_SHIFT;
    if (vs > BL_W'(32767)) sat = 16'sh7fff;
    else if (vs < -BL_W'(32768)) sat = -16'sh8000;
    else sat = vs[15:0];
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.is_eval && q_cmd.wr_ok) begin
      mem_a[base] <= {q_cmd.gx, q_cmd.gy};
      mem_b[base] <= {q_cmd.gx, q_cmd.gy};
    end
    if (en) begin
      rd00_r <= mem_a[a00];
      rd10_r <= mem_a[a10];
      rd01_r <= mem_b[a01];
      rd11_r <= mem_b[a11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= q_pop && q_cmd.is_eval;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor1_r  <= q_cmd.oor;
      fx1_r   <= q_cmd.fx;
      fy1_r   <= q_cmd.fy;
      atx1_r  <= fade_at(q_cmd.fx);
      aty1_r  <= fade_at(q_cmd.fy);
      ttx1_r  <= fade_sq(q_cmd.fx, q_cmd.fx);
      tty1_r  <= fade_sq(q_cmd.fy, q_cmd.fy);

      oor2_r  <= oor1_r;
      d00_2_r <= corner_dot(rd00_r[31:16], rd00_r[15:0], ox0, oy0);
      d10_2_r <= corner_dot(rd10_r[31:16], rd10_r[15:0], ox1, oy0);
      d01_2_r <= corner_dot(rd01_r[31:16], rd01_r[15:0], ox0, oy1);
      d11_2_r <= corner_dot(rd11_r[31:16], rd11_r[15:0], ox1, oy1);
      t3x2_r  <= fade_sq(ttx1_r, fx1_r);
      t3y2_r  <= fade_sq(tty1_r, fy1_r);
      cx2_r   <= fade_c(atx1_r);
      cy2_r   <= fade_c(aty1_r);

      oor3_r  <= oor2_r;
      d00_3_r <= d00_2_r;
      d10_3_r <= d10_2_r;
      d01_3_r <= d01_2_r;
      d11_3_r <= d11_2_r;
      ux3_r   <= fade_u(t3x2_r, cx2_r);
      uy3_r   <= fade_u(t3y2_r, cy2_r);

      oor4_r  <= oor3_r;
      i0_4_r  <= blend(BL_W'(d00_3_r), BL_W'(d10_3_r), ux3_r);
      i1_4_r  <= blend(BL_W'(d01_3_r), BL_W'(d11_3_r), ux3_r);
      uy4_r   <= uy3_r;

      out_r.out_of_range <= oor4_r;
      out_r.noise        <= oor4_r ? 16'sd0 : sat;
    end
  end

endmodule

>>> design/gradient_noise_2d_core.sv
// Channel   Ports                          Direction  Moves
// in        in_valid/in_ready/in_data      input      gradient write or noise sample
// out       out_valid/out_ready/out_data   output     noise result, one per sample
// cfg       psel/penable/pwrite/paddr/...  input      cells_in_use register
//
// One item per cycle sustained while the output is not stalled; gradient writes produce no result.
// A noise sample passes through the queue, then the table read, dot/fade, fade and x blend stages;
// the y blend and saturation land in the output register, which drives out_valid.
// rst_n is synchronous; the gradient table is not cleared and must be written first.
// A stalled output freezes the back end; the four-entry queue absorbs the front.
module gradient_noise_2d_core #(
  parameter int MAX_CELLS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gn2d_pkg::in_t         in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gn2d_pkg::out_t        out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import gn2d_pkg::*;

  logic [CFG_W-1:0] cells_r;
  cmd_t             f_cmd, q_cmd;
  logic             q_valid, q_pop;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'd0 || paddr != 2'd0);
  assign prdata = 32'(cells_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= CFG_RESET;
    end else if (cfg_wr && pready) begin
      cells_r <= pwdata[CFG_W-1:0];
    end
  end

  gn2d_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .in_data (in_data),
    .cells   (cells_r),
    .cmd     (f_cmd)
  );

  gn2d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_ready (in_ready),
    .push_data  (f_cmd),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd)
  );

  gn2d_back #(.MAX_CELLS(MAX_CELLS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> out_data.noise == 16'sd0)
    else $error("out-of-range result with nonzero noise");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("queue full yet empty");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> cells_r == $past(pwdata[CFG_W-1:0]))
    else $error("register write lost");
`endif

endmodule
